FILE: sv/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg - shared types and helpers for the case-folding substring search
// Beat layouts, configuration register indexes and the ASCII fold function.
// ----------------------------------------------------------------------------
package ssc_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FOLD    = 2'd2;

  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned IN_DATA_W  = 8;
  // found(1) + match_start(16) + length_overflow(1), padded to 3 bytes
  localparam int unsigned START_W    = 16;
  localparam int unsigned OUT_DATA_W = 24;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] pattern;
    logic [LEN_W-1:0]      length;
    logic                  fold;
  } cfg_t;

  typedef struct packed {
    logic [IN_DATA_W-1:0] text_byte;
    logic                 last;
  } item_t;

  typedef struct packed {
    logic               length_overflow;
    logic [START_W-1:0] match_start;
    logic               found;
  } result_t;

  // map A-Z to a-z when enabled, everything else passes unchanged
  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
    logic [7:0] r;
    r = c;
    if (en && (c >= 8'h41) && (c <= 8'h5A)) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

FILE: sv/ssc_front.sv
// ----------------------------------------------------------------------------
// ssc_front - input side of the substring search
// Takes text beats off the stream and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module ssc_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [ssc_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,   // text_byte
  input  logic                            s_axis_tlast_i,   // end_of_text
  output logic                            q_valid_o,
  output ssc_pkg::item_t                  q_item_o,
  input  logic                            q_pop_i
);

  ssc_pkg::item_t entries_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           push, pop;

  assign s_axis_tready_o = (count_q != 2'd2);
  assign q_valid_o       = (count_q != 2'd0);
  assign q_item_o        = entries_q[rd_ptr_q];

  assign push = s_axis_tvalid_i && s_axis_tready_o;
  assign pop  = q_pop_i && q_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= '{text_byte: s_axis_tdata_i, last: s_axis_tlast_i};
    end
  end

endmodule

FILE: sv/ssc_back.sv
// ----------------------------------------------------------------------------
// ssc_back - window compare and per-text tracking
// Keeps the recent text bytes, compares the window against the pattern,
// tracks position and first match, and registers one result per text.
// ----------------------------------------------------------------------------
module ssc_back #(
  parameter int unsigned MAX_PATTERN   = 8,
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ssc_pkg::cfg_t                   cfg_i,
  input  logic                            q_valid_i,
  input  ssc_pkg::item_t                  q_item_i,
  output logic                            q_pop_o,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output ssc_pkg::result_t                m_result_o
);

  localparam int unsigned HIST = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
  localparam int unsigned IW   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned PW1  = POSITION_BITS + 1;
  localparam logic [POSITION_BITS-1:0] PosMax = '1;

  logic [7:0]               hist_q [HIST];
  logic [7:0]               hist_d [HIST];
  logic [7:0]               win    [MAX_PATTERN];
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic                     seen_q, seen_d;
  logic [POSITION_BITS-1:0] start_q, start_d;
  logic                     sat_q, sat_d;

  logic                     out_valid_q, out_valid_d;
  ssc_pkg::result_t         out_q;
  ssc_pkg::result_t         result;

  logic                     pop, emit;
  logic                     sat_now;
  logic                     len_ok;
  logic                     cmp_ok;
  logic                     hit;
  logic [PW1-1:0]           pos_inc;
  logic [PW1-1:0]           len_ext;
  logic [IW-1:0]            idx;
  logic [31:0]              start_ext;

  // only a last beat needs the result slot
  assign pop     = q_valid_i && (!q_item_i.last || !out_valid_q || m_axis_tready_i);
  assign emit    = pop && q_item_i.last;
  assign q_pop_o = pop;

  // window: slot 0 is the current byte, then history newest first
  always_comb begin
    win[0] = q_item_i.text_byte;
    for (int j = 1; j < MAX_PATTERN; j++) begin
      win[j] = hist_q[j-1];
    end
  end

  always_comb begin
    pos_inc = PW1'(pos_q) + PW1'(1);
    len_ext = PW1'(cfg_i.length);
    len_ok  = (cfg_i.length != '0) &&
              (cfg_i.length <= ssc_pkg::LEN_W'(MAX_PATTERN)) &&
              (pos_inc >= len_ext);
    cmp_ok  = 1'b1;
    idx     = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (ssc_pkg::LEN_W'(i) < cfg_i.length) begin
        idx = IW'(cfg_i.length - ssc_pkg::LEN_W'(i) - ssc_pkg::LEN_W'(1));
        if (ssc_pkg::fold_byte(cfg_i.pattern[8*i +: 8], cfg_i.fold) !=
            ssc_pkg::fold_byte(win[idx], cfg_i.fold)) begin
          cmp_ok = 1'b0;
        end
      end
    end
  end

  always_comb begin
    sat_now = sat_q || (pos_q == PosMax);
    hit     = !sat_now && !seen_q && len_ok && cmp_ok;
    seen_d  = seen_q || hit;
    start_d = hit ? POSITION_BITS'(pos_inc - len_ext) : start_q;
    sat_d   = sat_now;
    pos_d   = (pos_q != PosMax) ? pos_q + POSITION_BITS'(1) : pos_q;
    hist_d[0] = q_item_i.text_byte;
    for (int k = 1; k < HIST; k++) begin
      hist_d[k] = hist_q[k-1];
    end
  end

  always_comb begin
    start_ext              = 32'(start_d);
    result.found           = seen_d;
    result.match_start     = seen_d ? start_ext[ssc_pkg::START_W-1:0] : '0;
    result.length_overflow = sat_d;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      seen_q      <= 1'b0;
      start_q     <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < HIST; k++) begin
        hist_q[k] <= '0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      if (emit) begin
        // end of text: start over for the next one
        pos_q   <= '0;
        seen_q  <= 1'b0;
        start_q <= '0;
        sat_q   <= 1'b0;
        for (int k = 0; k < HIST; k++) begin
          hist_q[k] <= '0;
        end
      end else if (pop) begin
        pos_q   <= pos_d;
        seen_q  <= seen_d;
        start_q <= start_d;
        sat_q   <= sat_d;
        for (int k = 0; k < HIST; k++) begin
          hist_q[k] <= hist_d[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_result_o      = out_q;

endmodule

FILE: sv/substring_search_case_fold.sv
// ----------------------------------------------------------------------------
// substring_search_case_fold - streaming first-match substring search
// Finds the first occurrence of a short pattern in each text, exact or with
// A-Z folded to a-z, and reports one result beat at the last text byte.
// ----------------------------------------------------------------------------
//  channel   dir  beat contents (low bit first)
//  s_axis    in   tdata: text_byte[7:0]; tlast: end_of_text
//  m_axis    out  tdata: found, match_start[15:0], length_overflow, pad
//  cfg       in   idx 0 pattern_bytes, 1 pattern_length, 2 fold_case
//
//  One text byte per cycle sustained while no result is stalled; a result passes
//  through the input queue, then the result register, after its last byte.
//  Reset clears the queue, per-text state and all configuration to zero.
//  A stalled result holds the back end only at the next last byte; the
//  two-entry queue then absorbs input until it fills.
// ----------------------------------------------------------------------------
module substring_search_case_fold #(
  parameter int unsigned MAX_PATTERN   = 8,
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ssc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ssc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [ssc_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,  // text_byte
  input  logic                              s_axis_tlast_i,  // end_of_text
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // found, match_start[15:0], length_overflow, zero pad
  output logic [ssc_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o
);

  ssc_pkg::cfg_t    cfg_q, cfg_d;
  logic             q_valid;
  ssc_pkg::item_t   q_item;
  logic             q_pop;
  ssc_pkg::result_t result;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ssc_pkg::CFG_PATTERN: cfg_d.pattern = cfg_wdata_i;
        ssc_pkg::CFG_LENGTH:  cfg_d.length  = cfg_wdata_i[ssc_pkg::LEN_W-1:0];
        ssc_pkg::CFG_FOLD:    cfg_d.fold    = cfg_wdata_i[0];
        default:              cfg_d         = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ssc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .q_valid_o       (q_valid),
    .q_item_o        (q_item),
    .q_pop_i         (q_pop)
  );

  ssc_back #(
    .MAX_PATTERN   (MAX_PATTERN),
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .q_valid_i       (q_valid),
    .q_item_i        (q_item),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_result_o      (result)
  );

  assign m_axis_tdata_o = ssc_pkg::OUT_DATA_W'(result);

endmodule
